>>> design/kuznyechik_block_cipher_macros.svh
// Assertion macros for the checker file of the cipher block.
`ifndef KUZNYECHIK_BLOCK_CIPHER_MACROS_SVH
`define KUZNYECHIK_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define KUZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define KUZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/kuz_pkg.sv
// Shared types, tables and GF(2^8) helpers for the cipher block.
package kuz_pkg;

  localparam int ROUND_COUNT = 10;
  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;

  typedef logic [7:0] sbox_t [256];
  typedef logic [BLOCK_BITS-1:0] block_t;

  typedef enum logic [2:0] {
    OP_X,
    OP_XS,
    OP_ISX,
    OP_LF,
    OP_LI
  } kuz_op_e;

  localparam sbox_t PI = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [7:0] L_COEF [BLOCK_BYTES] = '{
    8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
    8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
  };

  // Inverse table built at elaboration.
  function automatic sbox_t build_inv();
    sbox_t t;
    for (int k = 0; k < 256; k++) begin
      t[PI[k]] = 8'(k);
    end
    return t;
  endfunction

  localparam sbox_t PI_INV = build_inv();

  // Multiply in GF(2^8) mod x^8+x^7+x^6+x+1.
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ 8'hC3) : {x[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [7:0] lin_sum(block_t v);
    logic [7:0] s;
    s = '0;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      s = s ^ gf_mul(v[BLOCK_BITS-1-8*k -: 8], L_COEF[k]);
    end
    return s;
  endfunction

endpackage

>>> design/kuznyechik_block_cipher.sv
// Encrypt or decrypt runs on one shared round unit doing one S layer or one of 16 L
// steps per cycle; the unit is busy for the whole block. After a key write the next
// block first expands the keys.
// Reset (rst_ni low, async) clears key words to zero and marks keys not expanded.
module kuznyechik_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [63:0] block_hi_i,
  input  logic [63:0] block_lo_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_hi_o,
  output logic [63:0] result_lo_o
);
  import kuz_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_KROW0, S_KROW1, S_KC_INIT, S_KC_L, S_KA_XS, S_KA_L, S_KA_MIX,
    S_KA_WR, S_START, S_E_XS, S_E_L, S_E_FIN, S_D_X, S_D_L, S_D_IS, S_DONE
  } state_e;

  localparam logic [3:0] LAST_STEP  = 4'(BLOCK_BYTES - 1);
  localparam logic [3:0] LAST_ROUND = 4'(ROUND_COUNT - 1);
  localparam logic [3:0] PRE_ROUND  = 4'(ROUND_COUNT - 2);

  state_e      state_q;
  block_t      v_q, a1_q, a2_q, blk_q, res_q;
  logic        func_q, keys_ready_q, out_valid_q;
  logic [3:0]  step_q, rnd_q;
  logic [1:0]  ki_q;
  logic [2:0]  kj_q;
  logic [63:0] key_q [4];
  block_t      rk_q [ROUND_COUNT];

  kuz_op_e     u_op;
  block_t      u_data, u_key, u_res;
  logic        rk_we;
  logic [3:0]  rk_wa;
  block_t      rk_wd;
  block_t      mix_s;

  kuz_round_unit u_round (
    .op_i   (u_op),
    .data_i (u_data),
    .key_i  (u_key),
    .res_o  (u_res)
  );

  assign mix_s = v_q ^ a2_q;

  always_comb begin
    u_op   = OP_LF;
    u_data = v_q;
    u_key  = rk_q[rnd_q];
    unique case (state_q)
      S_KA_XS: begin
        u_op   = OP_XS;
        u_data = a1_q;
        u_key  = v_q;
      end
      S_E_XS:  u_op = OP_XS;
      S_E_FIN, S_D_X: u_op = OP_X;
      S_D_L:   u_op = OP_LI;
      S_D_IS:  u_op = OP_ISX;
      default: u_op = OP_LF;
    endcase
  end

  always_comb begin
    rk_we = 1'b0;
    rk_wa = '0;
    rk_wd = {key_q[0], key_q[1]};
    unique case (state_q)
      S_KROW0: rk_we = 1'b1;
      S_KROW1: begin
        rk_we = 1'b1;
        rk_wa = 4'd1;
        rk_wd = {key_q[2], key_q[3]};
      end
      S_KA_MIX: begin
        rk_we = (kj_q == 3'd7);
        rk_wa = {1'b0, ki_q, 1'b0} + 4'd2;
        rk_wd = mix_s;
      end
      S_KA_WR: begin
        rk_we = 1'b1;
        rk_wa = {1'b0, ki_q, 1'b0} + 4'd3;
        rk_wd = a2_q;
      end
      default: rk_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rk_we) rk_q[rk_wa] <= rk_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      step_q       <= '0;
      rnd_q        <= '0;
      ki_q         <= '0;
      kj_q         <= '0;
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
    end else begin
      if (cfg_we_i) begin
        key_q[cfg_idx_i] <= cfg_data_i;
        keys_ready_q     <= 1'b0;
      end
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        res_q       <= v_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            blk_q   <= {block_hi_i, block_lo_i};
            func_q  <= func_i;
            state_q <= keys_ready_q ? S_START : S_KROW0;
          end
        end
        S_KROW0: begin
          a1_q    <= {key_q[0], key_q[1]};
          state_q <= S_KROW1;
        end
        S_KROW1: begin
          a2_q    <= {key_q[2], key_q[3]};
          ki_q    <= '0;
          kj_q    <= '0;
          state_q <= S_KC_INIT;
        end
        S_KC_INIT: begin
          // round constant seed: index 8i+j+1 in the last byte
          v_q     <= {{(BLOCK_BITS-8){1'b0}}, {3'b000, ki_q, kj_q} + 8'd1};
          step_q  <= '0;
          state_q <= S_KC_L;
        end
        S_KC_L: begin
          v_q    <= u_res;
          step_q <= step_q + 4'd1;
          if (step_q == LAST_STEP) state_q <= S_KA_XS;
        end
        S_KA_XS: begin
          v_q     <= u_res;
          step_q  <= '0;
          state_q <= S_KA_L;
        end
        S_KA_L: begin
          v_q    <= u_res;
          step_q <= step_q + 4'd1;
          if (step_q == LAST_STEP) state_q <= S_KA_MIX;
        end
        S_KA_MIX: begin
          a1_q <= mix_s;
          a2_q <= a1_q;
          if (kj_q == 3'd7) begin
            state_q <= S_KA_WR;
          end else begin
            kj_q    <= kj_q + 3'd1;
            state_q <= S_KC_INIT;
          end
        end
        S_KA_WR: begin
          kj_q <= '0;
          if (ki_q == 2'd3) begin
            keys_ready_q <= 1'b1;
            state_q      <= S_START;
          end else begin
            ki_q    <= ki_q + 2'd1;
            state_q <= S_KC_INIT;
          end
        end
        S_START: begin
          v_q    <= blk_q;
          step_q <= '0;
          if (func_q) begin
            rnd_q   <= LAST_ROUND;
            state_q <= S_D_X;
          end else begin
            rnd_q   <= '0;
            state_q <= S_E_XS;
          end
        end
        S_E_XS: begin
          v_q     <= u_res;
          step_q  <= '0;
          state_q <= S_E_L;
        end
        S_E_L: begin
          v_q    <= u_res;
          step_q <= step_q + 4'd1;
          if (step_q == LAST_STEP) begin
            rnd_q   <= rnd_q + 4'd1;
            state_q <= (rnd_q == PRE_ROUND) ? S_E_FIN : S_E_XS;
          end
        end
        S_E_FIN: begin
          v_q     <= u_res;
          state_q <= S_DONE;
        end
        S_D_X: begin
          v_q     <= u_res;
          rnd_q   <= PRE_ROUND;
          step_q  <= '0;
          state_q <= S_D_L;
        end
        S_D_L: begin
          v_q    <= u_res;
          step_q <= step_q + 4'd1;
          if (step_q == LAST_STEP) state_q <= S_D_IS;
        end
        S_D_IS: begin
          v_q    <= u_res;
          step_q <= '0;
          if (rnd_q == '0) begin
            state_q <= S_DONE;
          end else begin
            rnd_q   <= rnd_q - 4'd1;
            state_q <= S_D_L;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_hi_o = res_q[BLOCK_BITS-1 -: 64];
  assign result_lo_o = res_q[63:0];

endmodule

>>> design/kuz_round_unit.sv
// Shared datapath unit: key XOR, S-box layers and one LFSR step of L or of its inverse.
module kuz_round_unit (
  input  kuz_pkg::kuz_op_e op_i,
  input  kuz_pkg::block_t  data_i,
  input  kuz_pkg::block_t  key_i,
  output kuz_pkg::block_t  res_o
);
  import kuz_pkg::*;

  block_t x_s;
  block_t sub_s;
  block_t isub_s;
  block_t rot_s;

  assign x_s   = data_i ^ key_i;
  assign rot_s = {data_i[BLOCK_BITS-9:0], data_i[BLOCK_BITS-1 -: 8]};

  always_comb begin
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      sub_s[8*k +: 8]  = PI[x_s[8*k +: 8]];
      isub_s[8*k +: 8] = PI_INV[data_i[8*k +: 8]] ^ key_i[8*k +: 8];
    end
  end

  always_comb begin
    unique case (op_i)
      OP_X:    res_o = x_s;
      OP_XS:   res_o = sub_s;
      OP_ISX:  res_o = isub_s;
      OP_LF:   res_o = {lin_sum(data_i), data_i[BLOCK_BITS-1:8]};
      OP_LI:   res_o = {rot_s[BLOCK_BITS-1:8], lin_sum(rot_s)};
      default: res_o = data_i;
    endcase
  end

endmodule

>>> design/kuz_checker.sv
// Port-level checker for the cipher block, bound to the top level.
`include "kuznyechik_block_cipher_macros.svh"

module kuz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_hi_o,
  input logic [63:0] result_lo_o
);

  // a stalled result holds
  `KUZ_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, $stable({out_valid_o, result_hi_o, result_lo_o}))

  // an accepted request keeps the block busy
  `KUZ_ASSERT_NXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only comes out of a busy block
  `KUZ_ASSERT_IMP(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind kuznyechik_block_cipher kuz_checker u_kuz_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for the 128-bit block cipher: directed rows, then random blocks.
module testbench;

  typedef logic [127:0] blk_t;

  typedef struct {
    bit          rekey;
    logic [63:0] key [4];
    logic        func;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          typed;
    blk_t        want;
  } stim_row_t;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;
  localparam logic [1:0] KEY_WORD_0 = 2'd0;
  localparam int NUM_ROUNDS = 10;
  localparam logic [7:0] GF_POLY = 8'hC3;
  localparam int MAX_GAP = 18;
  localparam int RUN_LIMIT = 4_000_000 * 4;

  localparam logic [7:0] SUBST [256] = '{
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [7:0] MIX_COEF [16] = '{
    8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
    8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = FUNC_ENC;
  logic [63:0] block_hi_i = '0;
  logic [63:0] block_lo_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] result_hi_o;
  logic [63:0] result_lo_o;

  kuznyechik_block_cipher uut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  inv_subst [256];
  logic [63:0] key_words [4];
  blk_t        sched_keys [NUM_ROUNDS];
  bit          schedule_valid;
  blk_t        pending_blocks [$];
  int          errors;
  bit          send_fast;
  bit          recv_fast;
  stim_row_t   rows [$];

  function automatic logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [7:0] mix_byte(blk_t v);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 16; k++) acc ^= gf_mult(v[127-8*k -: 8], MIX_COEF[k]);
    return acc;
  endfunction

  function automatic blk_t mix_fwd(blk_t v);
    for (int r = 0; r < 16; r++) v = {mix_byte(v), v[127:8]};
    return v;
  endfunction

  function automatic blk_t mix_inv(blk_t v);
    for (int r = 0; r < 16; r++) begin
      v = {v[119:0], v[127:120]};
      v[7:0] = mix_byte(v);
    end
    return v;
  endfunction

  function automatic blk_t subst_fwd(blk_t v);
    for (int k = 0; k < 16; k++) v[8*k +: 8] = SUBST[v[8*k +: 8]];
    return v;
  endfunction

  function automatic blk_t subst_inv(blk_t v);
    for (int k = 0; k < 16; k++) v[8*k +: 8] = inv_subst[v[8*k +: 8]];
    return v;
  endfunction

  // 32 Feistel steps, two round keys per group of eight
  function automatic void build_schedule();
    blk_t a1, a2, prev, c;
    sched_keys[0] = {key_words[0], key_words[1]};
    sched_keys[1] = {key_words[2], key_words[3]};
    for (int i = 0; i < 4; i++) begin
      a1 = sched_keys[2*i];
      a2 = sched_keys[2*i+1];
      for (int j = 0; j < 8; j++) begin
        c = mix_fwd(blk_t'(8*i + j + 1));
        prev = a1;
        a1 = mix_fwd(subst_fwd(a1 ^ c)) ^ a2;
        a2 = prev;
      end
      sched_keys[2*i+2] = a1;
      sched_keys[2*i+3] = a2;
    end
    schedule_valid = 1'b1;
  endfunction

  function automatic blk_t cipher_block(logic func, blk_t v);
    if (!schedule_valid) build_schedule();
    if (func == FUNC_ENC) begin
      for (int r = 0; r < NUM_ROUNDS - 1; r++) v = mix_fwd(subst_fwd(v ^ sched_keys[r]));
      v ^= sched_keys[NUM_ROUNDS-1];
    end else begin
      v ^= sched_keys[NUM_ROUNDS-1];
      for (int r = NUM_ROUNDS - 2; r >= 0; r--) v = subst_inv(mix_inv(v)) ^ sched_keys[r];
    end
    return v;
  endfunction

  function automatic int draw_gap(bit fast);
    return fast ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_blocks.size() != 0) @(posedge clk_i);
  endtask

  // writes the words selected by mask; block must be idle
  task automatic load_key(logic [63:0] words [4], logic [3:0] mask);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we_i <= 1'b1;
        cfg_idx_i <= KEY_WORD_0 + 2'(i);
        cfg_data_i <= words[i];
        @(posedge clk_i);
        key_words[i] = words[i];
        schedule_valid = 1'b0;
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_block(logic func, logic [63:0] hi, logic [63:0] lo, bit typed,
                            blk_t want);
    int gap;
    blk_t got;
    gap = draw_gap(send_fast);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    block_hi_i <= hi;
    block_lo_i <= lo;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    got = cipher_block(func, {hi, lo});
    pending_blocks = {pending_blocks, (typed ? want : got)};
  endtask

  task automatic add_row(bit rekey, logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                         logic [63:0] k3, logic func, logic [63:0] hi, logic [63:0] lo,
                         bit typed, blk_t want);
    stim_row_t r;
    r.rekey = rekey;
    r.key[0] = k0;
    r.key[1] = k1;
    r.key[2] = k2;
    r.key[3] = k3;
    r.func = func;
    r.hi = hi;
    r.lo = lo;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endtask

  // result side: check each accepted result, stall at random
  int stall_left = 0;
  always @(posedge clk_i) begin
    blk_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_blocks.size() == 0) begin
          $display("%0t: unexpected result %h_%h", $time, result_hi_o, result_lo_o);
          errors++;
        end else begin
          want = pending_blocks.pop_front();
          if (result_hi_o !== want[127:64]) begin
            $display("%0t: result_hi expected %h actual %h", $time, want[127:64], result_hi_o);
            errors++;
          end
          if (result_lo_o !== want[63:0]) begin
            $display("%0t: result_lo expected %h actual %h", $time, want[63:0], result_lo_o);
            errors++;
          end
        end
        if ($urandom_range(0, 15) == 0) recv_fast = !recv_fast;
        stall_left = draw_gap(recv_fast);
      end
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [63:0] kw [4];
    logic [3:0]  mask;
    logic        f;
    for (int k = 0; k < 256; k++) inv_subst[SUBST[k]] = 8'(k);
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    schedule_valid = 1'b0;
    errors = 0;
    send_fast = 1'b0;
    recv_fast = 1'b0;

    // blocks before any key write run on the all-zero key
    add_row(0, 0, 0, 0, 0, FUNC_ENC, '0, '0, 0, '0);
    add_row(0, 0, 0, 0, 0, FUNC_ENC, '1, '1, 0, '0);
    add_row(0, 0, 0, 0, 0, FUNC_DEC, '0, '0, 0, '0);
    add_row(0, 0, 0, 0, 0, FUNC_DEC, '1, '1, 0, '0);
    // published test vector
    add_row(1, 64'h8899aabbccddeeff, 64'h0011223344556677, 64'hfedcba9876543210,
            64'h0123456789abcdef, FUNC_ENC, 64'h1122334455667700, 64'hffeeddccbbaa9988,
            1, 128'h7f679d90bebc24305a468d42b9d4edcd);
    add_row(0, 0, 0, 0, 0, FUNC_DEC, 64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd,
            1, 128'h1122334455667700ffeeddccbbaa9988);
    add_row(0, 0, 0, 0, 0, FUNC_ENC, '0, '1, 0, '0);
    add_row(0, 0, 0, 0, 0, FUNC_DEC, '1, '0, 0, '0);
    add_row(0, 0, 0, 0, 0, FUNC_ENC, 64'h8000000000000000, 64'h1, 0, '0);
    add_row(1, '1, '1, '1, '1, FUNC_ENC, '0, '0, 0, '0);
    add_row(0, 0, 0, 0, 0, FUNC_DEC, '1, '1, 0, '0);
    add_row(1, 0, 0, 0, 0, FUNC_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0, '0);
    add_row(0, 0, 0, 0, 0, FUNC_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[n]) begin
      if (rows[n].rekey) begin
        in_valid_i <= 1'b0;
        wait_drained();
        @(posedge clk_i);
        load_key(rows[n].key, 4'hF);
      end
      send_block(rows[n].func, rows[n].hi, rows[n].lo, rows[n].typed, rows[n].want);
    end

    for (int ph = 0; ph < 10; ph++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      @(posedge clk_i);
      for (int i = 0; i < 4; i++) begin
        kw[i] = (ph == 1) ? '1 : (ph == 2) ? '0 : rand_word();
      end
      // partial rewrites leave the other words in place
      mask = (ph < 3) ? 4'hF : 4'($urandom_range(1, 15));
      load_key(kw, mask);
      for (int n = 0; n < 190; n++) begin
        if (n % 20 == 0) send_fast = ($urandom_range(0, 3) == 0);
        if (ph == 4 && n == 60) begin
          in_valid_i <= 1'b0;
          wait_drained();
          @(posedge clk_i);
        end
        f = 1'($urandom_range(0, 1));
        send_block(f, rand_word(), rand_word(), 0, '0);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
